// File: rtl/psc_pkg.sv
// Shared item types, error codes and fixed-point constants of the correlation statistics core.
package psc_pkg;

	typedef struct packed {
		logic signed [15:0] sample_a;
		logic signed [15:0] sample_b;
		logic               last_pair;
	} in_item_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_FEW      = 2'd1,
		ERR_FLAT     = 2'd2,
		ERR_CAPACITY = 2'd3
	} err_code_t;

	typedef struct packed {
		logic signed [31:0] mean_first;
		logic signed [31:0] mean_second;
		logic [30:0]        variance_first;
		logic [30:0]        variance_second;
		logic [30:0]        deviation_first;
		logic [30:0]        deviation_second;
		logic signed [31:0] covariance_out;
		logic signed [31:0] correlation_out;
		err_code_t          error_code;
	} out_item_t;

	localparam int ROOT_W     = 31;  // deviation width
	localparam int VAR_W      = 32;  // unsaturated variance kept for the square root
	localparam int CMAG_W     = 33;  // covariance magnitude kept for the correlation
	localparam int FRAC_SHIFT = 15;  // Q0.15 sum to Q2.30 mean
	localparam int VAR_SHIFT  = 30;  // Q2.30 variance to Q2.60, so the root comes out in Q1.30
	localparam int CORR_SHIFT = 60;  // covariance over product of deviations to Q2.30
	localparam int MIN_PAIRS  = 2;

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAG = 32'h8000_0000;

endpackage

// File: rtl/psc_stream_if.sv
// Valid/ready stream channel carrying one item of a given payload type.
interface psc_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/paired_series_correlation_stats_core.sv
// The running sums take each pair as it arrives; after the last pair of a set the result is worked out by
// the shared divider (up to six divisions of 93 bits), two 31-step square roots and a five-step product phase.
// Throughput: one pair per cycle unless the queue is full; two finished sets can wait there while one is worked out.
// Reset: arst_n clears the running sums, the queue and the sequencer at once; no clearing pass.
module paired_series_correlation_stats_core #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	psc_stream_if.sink   samples,
	psc_stream_if.source results
);
	import psc_pkg::*;

	// count holds MAX_SAMPLES itself; sums grow by the count's width
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = CW + 15;
	localparam int QW = CW + 30;
	localparam int XW = CW + 31;
	localparam int EW = 1 + CW + 2 * SW + 2 * QW + XW;

	logic          push_valid, push_ready, pop_valid, pop_ready;
	logic [EW-1:0] push_data, pop_data;

	// front end: take a pair every cycle while the queue has room, hand over the set on the last pair
	psc_front #(
		.MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .SW(SW), .QW(QW), .XW(XW), .EW(EW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .samples(samples),
		.push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
	);

	// queue: decouple accumulation from the long final arithmetic
	psc_queue #(.W(EW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(push_valid), .in_ready(push_ready), .in_data(push_data),
		.out_valid(pop_valid), .out_ready(pop_ready), .out_data(pop_data)
	);

	// back end: means, variances, roots, covariance and correlation, one set at a time
	psc_back #(.CW(CW), .SW(SW), .QW(QW), .XW(XW), .EW(EW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
		.results(results)
	);
endmodule

// File: rtl/psc_front.sv
// Front end: accumulate count, sums, squares and cross sum; hand a finished set to the queue.
module psc_front #(
	parameter int MAX_SAMPLES = 1024,
	parameter int CW = 11,
	parameter int SW = 26,
	parameter int QW = 41,
	parameter int XW = 42,
	parameter int EW = 1 + CW + 2 * SW + 2 * QW + XW
) (
	input  logic          clk,
	input  logic          arst_n,
	psc_stream_if.sink    samples,
	output logic          push_valid,
	input  logic          push_ready,
	output logic [EW-1:0] push_data
);
	import psc_pkg::*;

	logic [CW-1:0]        count_q, count_d;
	logic signed [SW-1:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
	logic [QW-1:0]        sq_a_q, sq_a_d, sq_b_q, sq_b_d;
	logic signed [XW-1:0] cross_q, cross_d;
	logic                 ovf_q, ovf_d;
	logic signed [31:0]   prod_aa, prod_bb, prod_ab;
	logic                 at_cap, accept;

	assign prod_aa = samples.data.sample_a * samples.data.sample_a;
	assign prod_bb = samples.data.sample_b * samples.data.sample_b;
	assign prod_ab = samples.data.sample_a * samples.data.sample_b;

	assign at_cap = (count_q == CW'(MAX_SAMPLES));
	assign accept = samples.valid & push_ready;
	assign samples.ready = push_ready;

	always_comb begin
		count_d = count_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		sq_a_d  = sq_a_q;
		sq_b_d  = sq_b_q;
		cross_d = cross_q;
		ovf_d   = ovf_q;
		if (at_cap) begin
			ovf_d = 1'b1;
		end else begin
			count_d = count_q + 1'b1;
			sum_a_d = sum_a_q + SW'(samples.data.sample_a);
			sum_b_d = sum_b_q + SW'(samples.data.sample_b);
			sq_a_d  = sq_a_q + QW'(prod_aa[30:0]);
			sq_b_d  = sq_b_q + QW'(prod_bb[30:0]);
			cross_d = cross_q + XW'(prod_ab);
		end
	end

	// the final pair is folded in before the set is handed over
	assign push_valid = samples.valid & samples.data.last_pair;
	assign push_data  = {ovf_d, count_d, sum_a_d, sum_b_d, sq_a_d, sq_b_d, cross_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			sq_a_q  <= '0;
			sq_b_q  <= '0;
			cross_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (samples.data.last_pair) begin
				count_q <= '0;
				sum_a_q <= '0;
				sum_b_q <= '0;
				sq_a_q  <= '0;
				sq_b_q  <= '0;
				cross_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_d;
				sum_a_q <= sum_a_d;
				sum_b_q <= sum_b_d;
				sq_a_q  <= sq_a_d;
				sq_b_q  <= sq_b_d;
				cross_q <= cross_d;
				ovf_q   <= ovf_d;
			end
		end
	end
endmodule

// File: rtl/psc_queue.sv
// Two-entry queue of finished sets between the front end and the back end.
module psc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   fill_q;
	logic         push, pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_data;
	end
endmodule

// File: rtl/psc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module psc_div #(
	parameter int NUM_W = 93,
	parameter int DEN_W = 62
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNTW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [DEN_W:0]   rem_sh, rem_nx;
	logic [CNTW-1:0]  cnt_q;
	logic             busy_q, done_q, take;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign take   = (rem_sh >= {1'b0, den_q});
	assign rem_nx = take ? (rem_sh - {1'b0, den_q}) : rem_sh;
	assign done   = done_q;
	assign quo    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], take};
			rem_q <= rem_nx[DEN_W-1:0];
		end
	end
endmodule

// File: rtl/psc_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module psc_sqrt #(
	parameter int RT = 31
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RT-1:0] rad,
	output logic            done,
	output logic [RT-1:0]   root
);
	localparam int CNTW = $clog2(RT + 1);

	logic [2*RT-1:0] x_q;
	logic [RT:0]     rem_q;
	logic [RT-1:0]   root_q;
	logic [RT+2:0]   rem_sh, trial, rem_nx;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q, done_q, take;

	assign rem_sh = {rem_q, x_q[2*RT-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = (rem_sh >= trial);
	assign rem_nx = take ? (rem_sh - trial) : rem_sh;
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RT);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[2*RT-3:0], 2'b00};
			rem_q  <= rem_nx[RT:0];
			root_q <= {root_q[RT-2:0], take};
		end
	end
endmodule

// File: rtl/psc_back.sv
// Back end: sequence products, divisions and roots for one set and register the result.
module psc_back #(
	parameter int CW = 11,
	parameter int SW = 26,
	parameter int QW = 41,
	parameter int XW = 42,
	parameter int EW = 1 + CW + 2 * SW + 2 * QW + XW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  logic [EW-1:0] pop_data,
	psc_stream_if.source  results
);
	import psc_pkg::*;

	localparam int DW       = CW + 1 + XW;
	localparam int CORR_NUM = CMAG_W + CORR_SHIFT;
	localparam int NUM_W    = (DW > CORR_NUM) ? DW : CORR_NUM;
	localparam int DEN_W    = (2 * CW > 2 * ROOT_W) ? 2 * CW : 2 * ROOT_W;

	localparam logic [2:0] J_MEAN_A = 3'd0;
	localparam logic [2:0] J_MEAN_B = 3'd1;
	localparam logic [2:0] J_VAR_A  = 3'd2;
	localparam logic [2:0] J_VAR_B  = 3'd3;
	localparam logic [2:0] J_COV    = 3'd4;
	localparam logic [2:0] J_CORR   = 3'd5;
	localparam logic [2:0] MUL_LAST = 3'd4;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_SQRT = 6'b001000,
		ST_DEN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [2:0]             job_q, mul_step_q;
	logic                   launched_q, sq_sel_q, cov_neg_q;
	logic                   e_ovf;
	logic [CW-1:0]          e_n;
	logic signed [SW-1:0]   e_sa, e_sb;
	logic [QW-1:0]          e_qa, e_qb;
	logic signed [XW-1:0]   e_xs;
	logic [CW-1:0]          n_q;
	logic signed [SW-1:0]   sa_q, sb_q;
	logic [QW-1:0]          qa_q, qb_q;
	logic signed [XW-1:0]   xs_q;
	logic signed [XW-1:0]   m_x;
	logic signed [SW-1:0]   m_s1, m_s2;
	logic signed [DW-1:0]   pn_d, pn_q, diff, dxx_q, dyy_q, dxy_q;
	logic signed [2*SW-1:0] ps_d, ps_q;
	logic [2*CW-1:0]        nn_q;
	logic [VAR_W-1:0]       var_a_q, var_b_q;
	logic [CMAG_W-1:0]      cmag_q;
	logic [2*ROOT_W-1:0]    den_q;
	logic [SW-1:0]          mag_sa, mag_sb;
	logic [DW-1:0]          mag_dxy;
	logic [NUM_W-1:0]       div_num, div_quo;
	logic [DEN_W-1:0]       div_den;
	logic                   div_start, div_done, sq_start, sq_done;
	logic [2*ROOT_W-1:0]    sq_rad;
	logic [ROOT_W-1:0]      sq_root;
	logic [31:0]            q_lo, corr_mag;
	logic signed [31:0]     mean_v, cov_v, corr_v;
	logic [30:0]            var_v;
	out_item_t              res_q, out_q, res_init;
	logic                   out_valid_q, out_free;

	assign {e_ovf, e_n, e_sa, e_sb, e_qa, e_qb, e_xs} = pop_data;
	assign pop_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || results.ready;

	// start a set cleared, with its error code when it ends early
	always_comb begin
		res_init = '0;
		if (e_ovf) res_init.error_code = ERR_CAPACITY;
		else if (e_n < CW'(MIN_PAIRS)) res_init.error_code = ERR_FEW;
	end

	// shared multipliers: n times a wide sum or n minus one, and sum times sum
	always_comb begin
		case (mul_step_q)
			3'd0: begin
				m_x  = signed'(XW'(qa_q));
				m_s1 = sa_q;
				m_s2 = sa_q;
			end
			3'd1: begin
				m_x  = signed'(XW'(qb_q));
				m_s1 = sb_q;
				m_s2 = sb_q;
			end
			3'd2: begin
				m_x  = xs_q;
				m_s1 = sa_q;
				m_s2 = sb_q;
			end
			default: begin
				m_x  = signed'(XW'(n_q - 1'b1));
				m_s1 = sa_q;
				m_s2 = sb_q;
			end
		endcase
	end

	assign pn_d = $signed({1'b0, n_q}) * m_x;
	assign ps_d = m_s1 * m_s2;
	assign diff = pn_q - DW'(ps_q);

	assign mag_sa  = sa_q[SW-1] ? unsigned'(-sa_q) : unsigned'(sa_q);
	assign mag_sb  = sb_q[SW-1] ? unsigned'(-sb_q) : unsigned'(sb_q);
	assign mag_dxy = dxy_q[DW-1] ? unsigned'(-dxy_q) : unsigned'(dxy_q);

	always_comb begin
		case (job_q)
			J_MEAN_A: begin
				div_num = NUM_W'({mag_sa, {FRAC_SHIFT{1'b0}}});
				div_den = DEN_W'(n_q);
			end
			J_MEAN_B: begin
				div_num = NUM_W'({mag_sb, {FRAC_SHIFT{1'b0}}});
				div_den = DEN_W'(n_q);
			end
			J_VAR_A: begin
				div_num = NUM_W'(unsigned'(dxx_q));
				div_den = DEN_W'(nn_q);
			end
			J_VAR_B: begin
				div_num = NUM_W'(unsigned'(dyy_q));
				div_den = DEN_W'(nn_q);
			end
			J_COV: begin
				div_num = NUM_W'(mag_dxy);
				div_den = DEN_W'(nn_q);
			end
			J_CORR: begin
				div_num = NUM_W'({cmag_q, {CORR_SHIFT{1'b0}}});
				div_den = DEN_W'(den_q);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_DIV) && !launched_q;
	assign sq_start  = (state_q == ST_SQRT) && !launched_q;
	assign sq_rad    = {(sq_sel_q ? var_b_q : var_a_q), {VAR_SHIFT{1'b0}}};

	psc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	psc_sqrt #(.RT(ROOT_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(sq_rad),
		.done(sq_done), .root(sq_root)
	);

	// shape the quotient for each field
	always_comb begin
		q_lo   = div_quo[31:0];
		mean_v = (job_q == J_MEAN_A ? sa_q[SW-1] : sb_q[SW-1]) ? -signed'(q_lo) : signed'(q_lo);
		var_v  = (|div_quo[NUM_W-1:31]) ? POS_MAX[30:0] : div_quo[30:0];
		if (dxy_q[DW-1]) begin
			cov_v = (div_quo > NUM_W'(NEG_MAG)) ? signed'(NEG_MAG) : -signed'(q_lo);
		end else begin
			cov_v = (div_quo > NUM_W'(POS_MAX)) ? signed'(POS_MAX) : signed'(q_lo);
		end
		corr_mag = (div_quo > NUM_W'(Q30_ONE)) ? Q30_ONE : q_lo;
		corr_v   = cov_neg_q ? -signed'(corr_mag) : signed'(corr_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= J_MEAN_A;
			mul_step_q  <= '0;
			launched_q  <= 1'b0;
			sq_sel_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (e_ovf || e_n < CW'(MIN_PAIRS)) begin
							state_q <= ST_OUT;
						end else begin
							state_q    <= ST_MUL;
							mul_step_q <= '0;
						end
					end
				end
				ST_MUL: begin
					mul_step_q <= mul_step_q + 3'd1;
					if (mul_step_q == MUL_LAST) begin
						state_q    <= ST_DIV;
						job_q      <= J_MEAN_A;
						launched_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_start) launched_q <= 1'b1;
					if (div_done) begin
						launched_q <= 1'b0;
						if (job_q == J_COV) begin
							state_q  <= ST_SQRT;
							sq_sel_q <= 1'b0;
						end else if (job_q == J_CORR) begin
							state_q <= ST_OUT;
						end else begin
							job_q <= job_q + 3'd1;
						end
					end
				end
				ST_SQRT: begin
					if (sq_start) launched_q <= 1'b1;
					if (sq_done) begin
						launched_q <= 1'b0;
						sq_sel_q   <= 1'b1;
						if (sq_sel_q) state_q <= ST_DEN;
					end
				end
				ST_DEN: begin
					if (res_q.deviation_first == '0 || res_q.deviation_second == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q    <= ST_DIV;
						job_q      <= J_CORR;
						launched_q <= 1'b0;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_q <= res_init;
				n_q   <= e_n;
				sa_q  <= e_sa;
				sb_q  <= e_sb;
				qa_q  <= e_qa;
				qb_q  <= e_qb;
				xs_q  <= e_xs;
			end
			ST_MUL: begin
				pn_q <= pn_d;
				ps_q <= ps_d;
				case (mul_step_q)
					3'd1: dxx_q <= diff;
					3'd2: dyy_q <= diff;
					3'd3: dxy_q <= diff;
					3'd4: nn_q  <= pn_q[2*CW-1:0];
					default: ;
				endcase
			end
			ST_DIV: begin
				if (div_done) begin
					case (job_q)
						J_MEAN_A: res_q.mean_first  <= mean_v;
						J_MEAN_B: res_q.mean_second <= mean_v;
						J_VAR_A: begin
							var_a_q              <= div_quo[VAR_W-1:0];
							res_q.variance_first <= var_v;
						end
						J_VAR_B: begin
							var_b_q               <= div_quo[VAR_W-1:0];
							res_q.variance_second <= var_v;
						end
						J_COV: begin
							cmag_q               <= div_quo[CMAG_W-1:0];
							cov_neg_q            <= dxy_q[DW-1];
							res_q.covariance_out <= cov_v;
						end
						J_CORR: res_q.correlation_out <= corr_v;
						default: ;
					endcase
				end
			end
			ST_SQRT: begin
				if (sq_done) begin
					if (sq_sel_q) res_q.deviation_second <= sq_root;
					else res_q.deviation_first <= sq_root;
				end
			end
			ST_DEN: begin
				den_q <= res_q.deviation_first * res_q.deviation_second;
				if (res_q.deviation_first == '0 || res_q.deviation_second == '0) begin
					res_q.error_code <= ERR_FLAT;
				end
			end
			ST_OUT: begin
				if (out_free) out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the division phase");

	a_err_zero_corr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error_code != ERR_NONE |-> out_q.correlation_out == '0)
		else $error("correlation given with an error code");

	a_corr_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.correlation_out <= signed'(Q30_ONE)
			&& out_q.correlation_out >= -signed'(Q30_ONE))
		else $error("correlation outside plus or minus one");
endmodule
